### rtl/nru_pkg.sv
`timescale 1ns / 1ps

package nru_pkg;

	localparam int MAX_FRAMES = 128;
	localparam int FRAME_W    = $clog2(MAX_FRAMES);
	localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;
	localparam int FC_W       = 8;
	localparam int INTV_W     = 20;
	localparam int ICNT_W     = 64;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_INTERVAL = 2'd1;

	localparam logic [FC_W-1:0]   FRAME_COUNT_RST    = 8'd128;
	localparam logic [INTV_W-1:0] RESET_INTERVAL_RST = 20'd50;
	localparam logic [ICNT_W-1:0] NEXT_RESET_AT_RST  = 64'd50;

	// class sentinel: above every real class
	localparam logic [2:0] CLASS_NONE = 3'd4;

	typedef enum logic [1:0] {
		OP_SELECT = 2'd0,
		OP_ACCESS = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_CLR,
		ST_PREP,
		ST_CHECK,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		op_t                operation;
		logic [FRAME_W-1:0] frame;
		logic               is_write;
		logic [ICNT_W-1:0]  instruction_count;
	} req_t;

	typedef struct packed {
		logic [FRAME_W-1:0] victim_frame;
		logic [1:0]         victim_class;
		logic               bits_were_reset;
	} rsp_t;

	// bit store write: data is {referenced, modified}
	typedef struct packed {
		logic               en;
		logic [FRAME_W-1:0] addr;
		logic [1:0]         data;
	} wr_t;

	typedef struct packed {
		logic init;
		logic eval;
	} best_ctl_t;

endpackage

### rtl/nru_bit_store.sv
`timescale 1ns / 1ps

// Per-frame {referenced, modified} bits. Entries never written read as zero.
module nru_bit_store (
	input  logic                                clk,
	input  logic                                arst_n,
	input  nru_pkg::wr_t                        wr,
	input  logic [nru_pkg::FRAME_W-1:0]         rd_addr,
	output logic [1:0]                          rd_bits
);

	logic [1:0]                     mem [nru_pkg::MAX_FRAMES];
	logic [nru_pkg::MAX_FRAMES-1:0] vld_q;
	logic [1:0]                     rd_data_s1;
	logic                           vld_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			vld_s1 <= vld_q[rd_addr];
		end
	end

	assign rd_bits = vld_s1 ? rd_data_s1 : 2'b00;

endmodule

### rtl/nru_best_unit.sv
`timescale 1ns / 1ps

// Shared compare unit: keep the first frame of the lowest class seen.
module nru_best_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  nru_pkg::best_ctl_t          ctl,
	input  logic [1:0]                  cls,
	input  logic [nru_pkg::FRAME_W-1:0] pos,
	output logic [nru_pkg::FRAME_W-1:0] best_pos,
	output logic [2:0]                  best_cls
);

	logic [nru_pkg::FRAME_W-1:0] best_pos_q;
	logic [2:0]                  best_cls_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_cls_q <= nru_pkg::CLASS_NONE;
			best_pos_q <= '0;
		end else if (ctl.init) begin
			best_cls_q <= nru_pkg::CLASS_NONE;
			best_pos_q <= '0;
		end else if (ctl.eval && ({1'b0, cls} < best_cls_q)) begin
			best_cls_q <= {1'b0, cls};
			best_pos_q <= pos;
		end
	end

	assign best_pos = best_pos_q;
	assign best_cls = best_cls_q;

endmodule

### rtl/nru_page_victim_select_top.sv
`timescale 1ns / 1ps

// Not-recently-used victim selector. Each frame carries a referenced and a
// modified bit held in a 128-entry bit store (entries never written read as
// zero, so no clearing pass follows reset). An access word reads the frame's
// bits and writes them back, a clear word writes them to zero, and an unused
// operation code is dropped with no result. A select word visits k frames:
// the scan reads one frame per cycle from the single read port of the bit
// store and feeds it to the one shared class comparator, so k runs from 1
// (a class-0 frame at the hand) up to frame_count (no class-0 frame, or a
// periodic clear, which always visits every active frame). Before the scan,
// PREP and CHECK settle the 64-bit threshold add and compare; the scan then
// primes its read pipeline, and EMIT loads the output register. The block
// takes one word at a time; a finished result sits in the output register,
// so access and clear words go on while it waits, and a later select holds
// in its last step until the slot frees.
// Configure only while idle; frame_count 0 acts as 1 and values above 128
// act as 128.
module nru_page_victim_select_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  nru_pkg::req_t                       req_word,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output nru_pkg::rsp_t                       rsp_word,
	input  logic                                cfg_we,
	input  logic [nru_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [nru_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	nru_pkg::state_t state_q, state_nx;

	// configuration and persistent state
	logic [nru_pkg::FC_W-1:0]    frame_count_q;
	logic [nru_pkg::INTV_W-1:0]  interval_q;
	logic [nru_pkg::ICNT_W-1:0]  next_reset_q;
	logic [nru_pkg::FRAME_W-1:0] hand_q;

	// current word
	nru_pkg::req_t               item_q;
	logic [nru_pkg::ICNT_W-1:0]  sum_q;
	logic                        clr_q;

	// scan sequencer
	logic [nru_pkg::FRAME_W-1:0] rpos_q;
	logic [nru_pkg::CNT_W-1:0]   iss_q;
	logic [nru_pkg::CNT_W-1:0]   ev_q;
	logic                        v_s1;
	logic [nru_pkg::FRAME_W-1:0] epos_s1;

	// output slot
	logic                        rsp_valid_q;
	nru_pkg::rsp_t               rsp_q;

	nru_pkg::wr_t                wr;
	nru_pkg::best_ctl_t          best_ctl;
	logic [nru_pkg::FRAME_W-1:0] rd_addr;
	logic [1:0]                  rd_bits;
	logic [nru_pkg::FRAME_W-1:0] best_pos;
	logic [2:0]                  best_cls;

	logic                        req_acc;
	logic                        slot_free;
	logic [nru_pkg::CNT_W-1:0]   n_act;
	logic [nru_pkg::FRAME_W-1:0] start_pos;
	logic [nru_pkg::FRAME_W-1:0] rpos_nx;
	logic [nru_pkg::CNT_W-1:0]   rpos_p1;
	logic [nru_pkg::CNT_W-1:0]   best_p1;
	logic                        issue;
	logic                        scan_last;

	assign req_stall = (state_q != nru_pkg::ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

	// clamp the frame count into 1..MAX_FRAMES
	always_comb begin
		if (frame_count_q == '0) begin
			n_act = nru_pkg::CNT_W'(1);
		end else if (nru_pkg::CNT_W'(frame_count_q) > nru_pkg::CNT_W'(nru_pkg::MAX_FRAMES)) begin
			n_act = nru_pkg::CNT_W'(nru_pkg::MAX_FRAMES);
		end else begin
			n_act = nru_pkg::CNT_W'(frame_count_q);
		end
	end

	// restart the hand at zero if the frame count has shrunk to or below it
	assign start_pos = ({1'b0, hand_q} >= n_act) ? '0 : hand_q;

	assign rpos_p1 = {1'b0, rpos_q} + nru_pkg::CNT_W'(1);
	assign rpos_nx = (rpos_p1 >= n_act) ? '0 : rpos_p1[nru_pkg::FRAME_W-1:0];
	assign best_p1 = {1'b0, best_pos} + nru_pkg::CNT_W'(1);

	assign issue     = (iss_q < n_act);
	// stop after the last active frame, or early on a class-0 frame unless clearing
	assign scan_last = v_s1 && ((ev_q == n_act - nru_pkg::CNT_W'(1)) ||
	                            (!clr_q && (rd_bits == 2'b00)));

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			nru_pkg::ST_IDLE: begin
				if (req_acc) begin
					case (req_word.operation)
						nru_pkg::OP_SELECT: state_nx = nru_pkg::ST_PREP;
						nru_pkg::OP_ACCESS: state_nx = nru_pkg::ST_ACC_RD;
						nru_pkg::OP_CLEAR:  state_nx = nru_pkg::ST_CLR;
						default:            state_nx = nru_pkg::ST_IDLE;
					endcase
				end
			end
			nru_pkg::ST_ACC_RD: state_nx = nru_pkg::ST_ACC_WR;
			nru_pkg::ST_ACC_WR: state_nx = nru_pkg::ST_IDLE;
			nru_pkg::ST_CLR:    state_nx = nru_pkg::ST_IDLE;
			nru_pkg::ST_PREP:   state_nx = nru_pkg::ST_CHECK;
			nru_pkg::ST_CHECK:  state_nx = nru_pkg::ST_SCAN;
			nru_pkg::ST_SCAN: begin
				if (scan_last) begin
					state_nx = nru_pkg::ST_EMIT;
				end
			end
			nru_pkg::ST_EMIT: begin
				if (slot_free) begin
					state_nx = nru_pkg::ST_IDLE;
				end
			end
			default: state_nx = nru_pkg::ST_IDLE;
		endcase
	end

	// bit store and compare unit control
	always_comb begin
		wr       = '0;
		rd_addr  = rpos_q;
		best_ctl = '0;
		case (state_q)
			nru_pkg::ST_ACC_RD: begin
				rd_addr = item_q.frame;
			end
			nru_pkg::ST_ACC_WR: begin
				// set referenced; set modified on a write, keep it otherwise
				wr.en   = 1'b1;
				wr.addr = item_q.frame;
				wr.data = {1'b1, rd_bits[0] | item_q.is_write};
			end
			nru_pkg::ST_CLR: begin
				wr.en   = 1'b1;
				wr.addr = item_q.frame;
				wr.data = 2'b00;
			end
			nru_pkg::ST_CHECK: begin
				best_ctl.init = 1'b1;
			end
			nru_pkg::ST_SCAN: begin
				best_ctl.eval = v_s1;
				// periodic clear: drop the referenced bit of each visited frame
				wr.en   = v_s1 && clr_q;
				wr.addr = epos_s1;
				wr.data = {1'b0, rd_bits[0]};
			end
			default: begin
				wr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= nru_pkg::ST_IDLE;
			frame_count_q <= nru_pkg::FRAME_COUNT_RST;
			interval_q    <= nru_pkg::RESET_INTERVAL_RST;
			next_reset_q  <= nru_pkg::NEXT_RESET_AT_RST;
			hand_q        <= '0;
			clr_q         <= 1'b0;
			rpos_q        <= '0;
			iss_q         <= '0;
			ev_q          <= '0;
			v_s1          <= 1'b0;
			epos_s1       <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			state_q <= state_nx;

			if (cfg_we) begin
				case (cfg_index)
					nru_pkg::REG_FRAME_COUNT:    frame_count_q <= cfg_wdata[nru_pkg::FC_W-1:0];
					nru_pkg::REG_RESET_INTERVAL: interval_q    <= cfg_wdata[nru_pkg::INTV_W-1:0];
					default: begin
					end
				endcase
			end

			case (state_q)
				nru_pkg::ST_CHECK: begin
					if (sum_q >= next_reset_q) begin
						clr_q        <= 1'b1;
						next_reset_q <= sum_q + nru_pkg::ICNT_W'(interval_q);
					end else begin
						clr_q <= 1'b0;
					end
					rpos_q <= start_pos;
					iss_q  <= '0;
					ev_q   <= '0;
					v_s1   <= 1'b0;
				end
				nru_pkg::ST_SCAN: begin
					v_s1 <= issue;
					if (issue) begin
						epos_s1 <= rpos_q;
						rpos_q  <= rpos_nx;
						iss_q   <= iss_q + nru_pkg::CNT_W'(1);
					end
					if (v_s1) begin
						ev_q <= ev_q + nru_pkg::CNT_W'(1);
					end
				end
				nru_pkg::ST_EMIT: begin
					if (slot_free) begin
						hand_q <= (best_p1 >= n_act) ? '0 : best_p1[nru_pkg::FRAME_W-1:0];
					end
				end
				default: begin
				end
			endcase

			if (state_q == nru_pkg::ST_EMIT && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			item_q <= req_word;
		end
		if (state_q == nru_pkg::ST_PREP) begin
			sum_q <= item_q.instruction_count + nru_pkg::ICNT_W'(1);
		end
		if (state_q == nru_pkg::ST_EMIT && slot_free) begin
			rsp_q.victim_frame    <= best_pos;
			rsp_q.victim_class    <= best_cls[1:0];
			rsp_q.bits_were_reset <= clr_q;
		end
	end

	nru_bit_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_bits (rd_bits)
	);

	nru_best_unit u_best (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (best_ctl),
		.cls      (rd_bits),
		.pos      (epos_s1),
		.best_pos (best_pos),
		.best_cls (best_cls)
	);

	// never issue past the active frame count
	a_iss_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nru_pkg::ST_SCAN) |-> (iss_q <= n_act))
		else $error("scan issued more reads than active frames");

	// evaluation count stays below the frame count while scanning
	a_ev_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nru_pkg::ST_SCAN) |-> (ev_q < n_act))
		else $error("scan evaluated past the last active frame");

	// scan writes only during a periodic clear
	a_scan_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nru_pkg::ST_SCAN && wr.en) |-> clr_q)
		else $error("bit store written during a plain scan");

	// a victim has been found before the result is loaded
	a_emit_best: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nru_pkg::ST_EMIT) |-> (best_cls[2] == 1'b0))
		else $error("result loaded without a victim");

	// an evaluated frame is the one issued in the cycle before
	a_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nru_pkg::ST_SCAN && issue) |=> (v_s1 && epos_s1 == $past(rpos_q)))
		else $error("scan pipeline lost a frame");

endmodule

### tb/sv/nru_victim_checker.sv
`timescale 1ns / 1ps

module nru_victim_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	input  logic                           req_stall,
	input  nru_pkg::req_t                  req_word,
	input  logic                           rsp_valid,
	input  logic                           rsp_stall,
	input  nru_pkg::rsp_t                  rsp_word,
	input  logic                           cfg_we,
	input  logic [nru_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nru_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                             mismatches,
	output int                             pending,
	output int                             victims_checked,
	output int                             sweeps_seen
);

	logic                       ref_bit [nru_pkg::MAX_FRAMES];
	logic                       mod_bit [nru_pkg::MAX_FRAMES];
	int                         hand;
	logic [nru_pkg::ICNT_W-1:0] sweep_at;
	logic [nru_pkg::FC_W-1:0]   frame_cnt;
	logic [nru_pkg::INTV_W-1:0] interval;
	nru_pkg::rsp_t              victim_q [$];

	// one select: advance hand, maybe sweep referenced bits, return the victim
	function automatic nru_pkg::rsp_t pick_victim(input logic [nru_pkg::ICNT_W-1:0] count);
		int                         n;
		int                         pos;
		int                         best;
		int                         best_cls;
		int                         cls;
		int                         i;
		bit                         done;
		logic                       sweeping;
		logic [nru_pkg::ICNT_W-1:0] nxt;
		nru_pkg::rsp_t              r;
		if (frame_cnt == 0) n = 1;
		else if (frame_cnt > nru_pkg::MAX_FRAMES) n = nru_pkg::MAX_FRAMES;
		else n = int'(frame_cnt);
		nxt = count + 64'd1;
		sweeping = (nxt >= sweep_at);
		if (sweeping) sweep_at = nxt + nru_pkg::ICNT_W'(interval);
		if (hand >= n) hand = 0;
		pos = hand;
		best = 0;
		best_cls = 4;
		done = 1'b0;
		i = 0;
		while (i < n && !done) begin
			cls = (ref_bit[pos] ? 2 : 0) + (mod_bit[pos] ? 1 : 0);
			if (cls < best_cls) begin
				best_cls = cls;
				best = pos;
			end
			if (sweeping) ref_bit[pos] = 1'b0;
			else if (cls == 0) done = 1'b1;
			pos++;
			if (pos >= n) pos = 0;
			i++;
		end
		hand = best + 1;
		if (hand >= n) hand = 0;
		r.victim_frame    = nru_pkg::FRAME_W'(best);
		r.victim_class    = 2'(best_cls);
		r.bits_were_reset = sweeping;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		nru_pkg::rsp_t want;
		if (!arst_n) begin
			for (int k = 0; k < nru_pkg::MAX_FRAMES; k++) begin
				ref_bit[k] = 1'b0;
				mod_bit[k] = 1'b0;
			end
			hand            = 0;
			sweep_at        = nru_pkg::NEXT_RESET_AT_RST;
			frame_cnt       = nru_pkg::FRAME_COUNT_RST;
			interval        = nru_pkg::RESET_INTERVAL_RST;
			victim_q.delete();
			pending         = 0;
			mismatches      = 0;
			victims_checked = 0;
			sweeps_seen     = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == nru_pkg::REG_FRAME_COUNT)
					frame_cnt = cfg_wdata[nru_pkg::FC_W-1:0];
				else if (cfg_index == nru_pkg::REG_RESET_INTERVAL)
					interval = cfg_wdata[nru_pkg::INTV_W-1:0];
			end
			if (req_valid && !req_stall) begin
				case (req_word.operation)
					nru_pkg::OP_SELECT:
						victim_q.push_back(pick_victim(req_word.instruction_count));
					nru_pkg::OP_ACCESS: begin
						ref_bit[req_word.frame] = 1'b1;
						if (req_word.is_write) mod_bit[req_word.frame] = 1'b1;
					end
					nru_pkg::OP_CLEAR: begin
						ref_bit[req_word.frame] = 1'b0;
						mod_bit[req_word.frame] = 1'b0;
					end
					default: ;
				endcase
			end
			if (rsp_valid && !rsp_stall) begin
				if (victim_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, got frame %0d class %0d reset %0b",
						$time, rsp_word.victim_frame, rsp_word.victim_class,
						rsp_word.bits_were_reset);
				end else begin
					want = victim_q.pop_front();
					victims_checked++;
					if (rsp_word.bits_were_reset) sweeps_seen++;
					if (rsp_word.victim_frame !== want.victim_frame) begin
						mismatches++;
						$display("%0t: victim_frame expected %0d got %0d",
							$time, want.victim_frame, rsp_word.victim_frame);
					end
					if (rsp_word.victim_class !== want.victim_class) begin
						mismatches++;
						$display("%0t: victim_class expected %0d got %0d",
							$time, want.victim_class, rsp_word.victim_class);
					end
					if (rsp_word.bits_were_reset !== want.bits_were_reset) begin
						mismatches++;
						$display("%0t: bits_were_reset expected %0b got %0b",
							$time, want.bits_were_reset, rsp_word.bits_were_reset);
					end
				end
			end
			pending = victim_q.size();
		end
	end

endmodule

### tb/sv/nru_page_victim_select_top_test.sv
`timescale 1ns / 1ps

module nru_page_victim_select_top_test;

	// op code 3 is not decoded by the block: it must be dropped without a result
	localparam nru_pkg::op_t OP_UNUSED = nru_pkg::op_t'(2'd3);
	// an access word is the slowest word that leaves no result behind
	localparam int SETTLE_CYCLES = 8;
	// a full 128-frame select plus the longest stall fits many times over
	localparam int IDLE_LIMIT = 4000;
	localparam int TAIL_CYCLES = 200;

	logic                           clk;
	logic                           arst_n;
	logic                           req_valid;
	logic                           req_stall;
	nru_pkg::req_t                  req_word;
	logic                           rsp_valid;
	logic                           rsp_stall;
	nru_pkg::rsp_t                  rsp_word;
	logic                           cfg_we;
	logic [nru_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [nru_pkg::CFG_DATA_W-1:0] cfg_wdata;

	int mismatches;
	int pending;
	int victims_checked;
	int sweeps_seen;

	bit                         calm;
	int                         stall_left;
	int                         idle_cycles;
	int                         words_sent;
	int                         settings;
	logic [nru_pkg::ICNT_W-1:0] icount;

	nru_page_victim_select_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	nru_victim_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.req_word        (req_word),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.rsp_word        (rsp_word),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.mismatches      (mismatches),
		.pending         (pending),
		.victims_checked (victims_checked),
		.sweeps_seen     (sweeps_seen)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Mostly back-to-back, sometimes a short gap, rarely a long one.
	// A calm phase runs with no gaps at all.
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Receiver back-pressure: stall bursts of random length, changed at the
	// falling edge so the block sees a stable value at the rising edge.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_stall = 1'b1;
			stall_left--;
		end else begin
			rsp_stall = 1'b0;
			if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
		end
	end

	// Watchdog: count cycles in which no word moves on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
				$display("nru_page_victim_select_top_test failed");
				$finish;
			end
		end
	end

	function automatic nru_pkg::req_t make_word(input nru_pkg::op_t op, input int fr,
			input bit wr, input logic [nru_pkg::ICNT_W-1:0] cnt);
		nru_pkg::req_t w;
		w.operation         = op;
		w.frame             = nru_pkg::FRAME_W'(fr);
		w.is_write          = wr;
		w.instruction_count = cnt;
		return w;
	endfunction

	// Random word. The instruction count mostly creeps forward so periodic
	// sweeps keep happening; now and then it jumps to a random or near-wrap
	// value, and the running count follows the jump.
	function automatic nru_pkg::req_t rand_word(input int span);
		nru_pkg::req_t w;
		int            r;
		r = $urandom_range(0, 99);
		if (r < 22) w.operation = nru_pkg::OP_SELECT;
		else if (r < 62) w.operation = nru_pkg::OP_ACCESS;
		else if (r < 90) w.operation = nru_pkg::OP_CLEAR;
		else w.operation = OP_UNUSED;
		if ($urandom_range(0, 7) == 0) w.frame = nru_pkg::FRAME_W'($urandom);
		else w.frame = nru_pkg::FRAME_W'($urandom_range(0, span));
		w.is_write = 1'($urandom_range(0, 1));
		icount = icount + nru_pkg::ICNT_W'($urandom_range(0, 12));
		r = $urandom_range(0, 49);
		if (r == 0) icount = {$urandom, $urandom};
		else if (r == 1) icount = ~64'd0 - nru_pkg::ICNT_W'($urandom_range(0, 3));
		w.instruction_count = icount;
		return w;
	endfunction

	// Present one word after a random gap and hold it until accepted.
	// Entered and left at a falling edge; valid drops once the word is taken.
	task automatic send_word(input nru_pkg::req_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_word  = w;
		req_valid = 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
		req_valid = 1'b0;
		words_sent++;
	endtask

	// Hold the sender until every select has answered, then let any trailing
	// access or clear word finish inside the block.
	task automatic wait_drain();
		req_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write both registers while the block is idle. Upper data bits of the
	// frame count are junk on purpose: only the low byte is the register.
	task automatic set_regs(input logic [nru_pkg::FC_W-1:0] fc,
			input logic [nru_pkg::INTV_W-1:0] iv);
		wait_drain();
		cfg_we    = 1'b1;
		cfg_index = nru_pkg::REG_FRAME_COUNT;
		cfg_wdata = {(nru_pkg::CFG_DATA_W - nru_pkg::FC_W)'($urandom), fc};
		@(negedge clk);
		cfg_index = nru_pkg::REG_RESET_INTERVAL;
		cfg_wdata = nru_pkg::CFG_DATA_W'(iv);
		@(negedge clk);
		cfg_we = 1'b0;
		settings++;
	endtask

	task automatic run_phase(input logic [nru_pkg::FC_W-1:0] fc,
			input logic [nru_pkg::INTV_W-1:0] iv, input bit quiet, input int items);
		int span;
		set_regs(fc, iv);
		calm = quiet;
		// aim frames at the active window plus one beyond it
		if (fc == 0) span = 1;
		else if (fc >= 127) span = 127;
		else span = int'(fc);
		for (int k = 0; k < items; k++) begin
			// pause the sender midway until the block has answered everything
			if (k == items / 2) wait_drain();
			send_word(rand_word(span));
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req_word    = '0;
		rsp_stall   = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_wdata   = '0;
		calm        = 1'b0;
		stall_left  = 0;
		idle_cycles = 0;
		words_sent  = 0;
		settings    = 0;
		icount      = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: reset settings are 128 frames and a sweep every 50.
		// All frames class 0: the frame at the hand wins.
		send_word(make_word(nru_pkg::OP_SELECT, 0, 1'b0, 64'd0));
		send_word(make_word(nru_pkg::OP_ACCESS, 127, 1'b1, 64'd0));
		send_word(make_word(nru_pkg::OP_ACCESS, 0, 1'b0, 64'd0));
		send_word(make_word(nru_pkg::OP_ACCESS, 1, 1'b1, 64'd0));
		send_word(make_word(nru_pkg::OP_ACCESS, 2, 1'b1, 64'd0));
		send_word(make_word(nru_pkg::OP_CLEAR, 1, 1'b0, 64'd0));
		// unused op code with every other field at its top: drop it
		send_word(make_word(OP_UNUSED, 127, 1'b1, ~64'd0));
		// one below the threshold: no sweep, stop at the first class-0 frame
		send_word(make_word(nru_pkg::OP_SELECT, 0, 1'b0, 64'd48));
		// count + 1 wraps to zero, which is below the threshold
		send_word(make_word(nru_pkg::OP_SELECT, 0, 1'b0, ~64'd0));
		// exactly at the threshold: full sweep of all 128 frames
		send_word(make_word(nru_pkg::OP_SELECT, 0, 1'b0, 64'd49));

		// Shrink to 3 frames with a zero interval: the hand restarts at zero,
		// and with every frame class 3 the scan finds no class-0 frame.
		set_regs(8'd3, 20'd0);
		send_word(make_word(nru_pkg::OP_ACCESS, 0, 1'b1, 64'd0));
		send_word(make_word(nru_pkg::OP_ACCESS, 1, 1'b1, 64'd0));
		send_word(make_word(nru_pkg::OP_ACCESS, 2, 1'b1, 64'd0));
		send_word(make_word(nru_pkg::OP_SELECT, 0, 1'b0, 64'd5));
		send_word(make_word(nru_pkg::OP_SELECT, 0, 1'b0, 64'd99));
		send_word(make_word(nru_pkg::OP_SELECT, 0, 1'b0, 64'd99));

		// A zero frame count acts as one frame.
		set_regs(8'd0, 20'd1);
		send_word(make_word(nru_pkg::OP_SELECT, 0, 1'b0, 64'd1));
		send_word(make_word(nru_pkg::OP_SELECT, 0, 1'b0, 64'd1));

		// Frame count above the maximum, widest interval: the new threshold
		// wraps past 2^64.
		set_regs(8'd255, 20'hFFFFF);
		send_word(make_word(nru_pkg::OP_SELECT, 0, 1'b0, 64'hFFFF_FFFF_FFFF_FFF0));
		send_word(make_word(nru_pkg::OP_SELECT, 0, 1'b0, 64'd5));
		send_word(make_word(nru_pkg::OP_SELECT, 0, 1'b0, 64'd2_000_000));

		// Random phases across several settings; the first one has no random gaps.
		icount = 64'd0;
		run_phase(8'd128, 20'd50, 1'b1, 85);
		run_phase(8'd4, 20'd10, 1'b0, 85);
		run_phase(8'd0, 20'd0, 1'b0, 85);
		run_phase(8'd255, 20'hFFFFF, 1'b0, 85);
		run_phase(8'd1, 20'd1, 1'b0, 85);
		run_phase(8'd17, nru_pkg::INTV_W'($urandom_range(1, 1000)), 1'b0, 85);
		run_phase(8'd2, 20'd3, 1'b0, 85);

		// Drain, then give the block room to show any stray result.
		req_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("ran %0d words over %0d register settings", words_sent, settings);
		$display("checked %0d victims, %0d of them with a referenced-bit sweep",
			victims_checked, sweeps_seen);
		if (mismatches == 0 && pending == 0) begin
			$display("nru_page_victim_select_top_test passed");
		end else begin
			$display("nru_page_victim_select_top_test failed");
		end
		$finish;
	end

endmodule
